### rtl/urb_pkg.sv
// Shared types and constants for the serial port receive and transmit ring buffers.
`default_nettype none

package urb_pkg;

    localparam int unsigned RX_DEPTH_DEF = 64;
    localparam int unsigned TX_DEPTH_DEF = 64;
    localparam int unsigned BYTE_W       = 8;

    typedef enum logic [1:0] {
        MODE_RX_BYTE  = 2'd0,
        MODE_SW_READ  = 2'd1,
        MODE_SW_SEND  = 2'd2,
        MODE_TX_READY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RX_EMPTY = 3'd1,
        ST_TX_FULL  = 3'd2,
        ST_RX_DROP  = 3'd3,
        ST_TX_IDLE  = 3'd4
    } status_t;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        byte_t wr_data;
    } ring_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

`default_nettype wire

### rtl/urb_if.sv
// Request and result channel interfaces for the ring buffer block.
`default_nettype none

interface urb_cmd_if;
    import urb_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    byte_t data_in;

    modport source (output valid, output mode, output data_in, input ready);
    modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface urb_result_if;
    import urb_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    byte_t   data_out;
    logic    data_valid;
    logic    tx_request;

    modport source (output valid, output status, output data_out, output data_valid,
                    output tx_request, input ready);
    modport sink   (input valid, input status, input data_out, input data_valid,
                    input tx_request, output ready);
endinterface

`default_nettype wire

### rtl/uart_rx_tx_ring_buffers.sv
// Top level: serial port receive and transmit ring buffers with request/result channels.
// Two-stage pipeline: a request is registered in the first stage, then in the output stage.
// Throughput: one request per cycle unless results stall; the memory read is registered.
// Backpressure on the result channel stalls the pipeline; the request side stalls only when full.
// Reset clears both rings' pointers, the transmit-request flag and the pipeline valids.
// Ring memories are not cleared; only entries already written are ever read.
`default_nettype none

module uart_rx_tx_ring_buffers #(
    parameter int unsigned RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    urb_cmd_if.sink     cmd,
    urb_result_if.source result
);
    import urb_pkg::*;

    ring_ctl_t  rx_ctl;
    ring_ctl_t  tx_ctl;
    ring_stat_t rx_stat;
    ring_stat_t tx_stat;
    byte_t      rx_rd_data;
    byte_t      tx_rd_data;

    logic    accept;
    logic    s1_adv;
    status_t status_now;
    logic    dv_now;
    logic    flag_next;
    logic    flag_reg;

    logic    s1_valid_reg;
    status_t s1_status_reg;
    logic    s1_dv_reg;
    logic    s1_tx_reg;
    logic    s1_flag_reg;

    logic    out_valid_reg;
    status_t out_status_reg;
    byte_t   out_data_reg;
    logic    out_dv_reg;
    logic    out_flag_reg;

    urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rx_ctl),
        .stat    (rx_stat),
        .rd_data (rx_rd_data)
    );

    urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tx_ctl),
        .stat    (tx_stat),
        .rd_data (tx_rd_data)
    );

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        rx_ctl     = '{push: 1'b0, pop: 1'b0, wr_data: cmd.data_in};
        tx_ctl     = '{push: 1'b0, pop: 1'b0, wr_data: cmd.data_in};
        status_now = ST_OK;
        dv_now     = 1'b0;
        flag_next  = flag_reg;
        case (cmd.mode)
            MODE_RX_BYTE:
            begin
                if (rx_stat.full)
                begin
                    status_now = ST_RX_DROP;
                end
                else
                begin
                    rx_ctl.push = accept;
                end
            end
            MODE_SW_READ:
            begin
                if (rx_stat.empty)
                begin
                    status_now = ST_RX_EMPTY;
                end
                else
                begin
                    rx_ctl.pop = accept;
                    dv_now     = 1'b1;
                end
            end
            MODE_SW_SEND:
            begin
                if (tx_stat.full)
                begin
                    status_now = ST_TX_FULL;
                end
                else
                begin
                    tx_ctl.push = accept;
                    flag_next   = 1'b1;
                end
            end
            MODE_TX_READY:
            begin
                if (!flag_reg)
                begin
                    status_now = ST_TX_IDLE;
                end
                else if (tx_stat.empty)
                begin
                    status_now = ST_TX_IDLE;
                    flag_next  = 1'b0;
                end
                else
                begin
                    tx_ctl.pop = accept;
                    dv_now     = 1'b1;
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                flag_reg <= flag_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_now;
            s1_dv_reg     <= dv_now;
            s1_tx_reg     <= (cmd.mode == MODE_TX_READY);
            s1_flag_reg   <= flag_next;
        end
        if (s1_adv)
        begin
            out_status_reg <= s1_status_reg;
            out_dv_reg     <= s1_dv_reg;
            out_flag_reg   <= s1_flag_reg;
            if (!s1_dv_reg)
            begin
                out_data_reg <= '0;
            end
            else if (s1_tx_reg)
            begin
                out_data_reg <= tx_rd_data;
            end
            else
            begin
                out_data_reg <= rx_rd_data;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.data_out   = out_data_reg;
    assign result.data_valid = out_dv_reg;
    assign result.tx_request = out_flag_reg;

endmodule

`default_nettype wire

### rtl/urb_ring.sv
// One ring buffer: storage memory, write and read pointers, registered read data.
`default_nettype none

module urb_ring #(
    parameter int unsigned DEPTH = urb_pkg::RX_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire urb_pkg::ring_ctl_t ctl,
    output urb_pkg::ring_stat_t     stat,
    output urb_pkg::byte_t          rd_data
);
    import urb_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    byte_t         mem [DEPTH];
    byte_t         rd_data_reg;
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW-1:0] wr_ptr_inc;
    logic [AW-1:0] rd_ptr_inc;

    always_comb
    begin
        wr_ptr_inc  = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        rd_ptr_inc  = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        stat.full   = (wr_ptr_inc == rd_ptr_reg);
        stat.empty  = (wr_ptr_reg == rd_ptr_reg);
        wr_ptr_next = ctl.push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? rd_ptr_inc : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= ctl.wr_data;
        end
        if (ctl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/urb_checker.sv
// Port-level checker for the ring buffer block, bound to the top level.
`default_nettype none

module urb_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             cmd_valid,
    input wire logic             cmd_ready,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire urb_pkg::status_t res_status,
    input wire urb_pkg::byte_t   res_data_out,
    input wire logic             res_data_valid,
    input wire logic             res_tx_request
);
    import urb_pkg::*;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> ##1 res_valid)
        else $error("accepted request did not produce a result");

    a_data_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data_valid |-> res_status == ST_OK)
        else $error("byte delivered with non-ok status");

    a_tx_full_flag_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_TX_FULL |-> res_tx_request)
        else $error("transmit ring full while request flag clear");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_data_out) && $stable(res_data_valid) && $stable(res_tx_request))
        else $error("stalled result changed");

endmodule

bind uart_rx_tx_ring_buffers urb_checker u_urb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_status     (result.status),
    .res_data_out   (result.data_out),
    .res_data_valid (result.data_valid),
    .res_tx_request (result.tx_request)
);

`default_nettype wire

### dv/uart_rx_tx_ring_buffers_tb.sv
// Testbench for the serial port ring buffers: random request traffic checked against a predictor.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_tb;
    import urb_pkg::*;

    localparam int unsigned RX_SLOTS       = RX_DEPTH_DEF;
    localparam int unsigned TX_SLOTS       = TX_DEPTH_DEF;
    localparam int unsigned HALF_PERIOD    = 2;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned PHASE_ITEMS    = 185;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        status_t status;
        byte_t   data_out;
        logic    data_valid;
        logic    tx_request;
    } ring_result_t;

    class ring_scoreboard;
        byte_t        rx_mem [RX_SLOTS];
        byte_t        tx_mem [TX_SLOTS];
        int unsigned  rx_wr;
        int unsigned  rx_rd;
        int unsigned  tx_wr;
        int unsigned  tx_rd;
        bit           tx_req;
        ring_result_t awaited [$];
        int unsigned  errors;

        function new();
            rx_wr  = 0;
            rx_rd  = 0;
            tx_wr  = 0;
            tx_rd  = 0;
            tx_req = 1'b0;
            errors = 0;
        endfunction

        function int unsigned bump(int unsigned ptr, int unsigned depth);
            return (ptr + 1 >= depth) ? 0 : ptr + 1;
        endfunction

        function void note_request(mode_t m, byte_t d);
            ring_result_t r;
            int unsigned  nxt;
            r.status     = ST_OK;
            r.data_out   = '0;
            r.data_valid = 1'b0;
            case (m)
                MODE_RX_BYTE:
                begin
                    nxt = bump(rx_wr, RX_SLOTS);
                    if (nxt == rx_rd)
                    begin
                        r.status = ST_RX_DROP;
                    end
                    else
                    begin
                        rx_mem[rx_wr] = d;
                        rx_wr = nxt;
                    end
                end
                MODE_SW_READ:
                begin
                    if (rx_wr == rx_rd)
                    begin
                        r.status = ST_RX_EMPTY;
                    end
                    else
                    begin
                        r.data_out   = rx_mem[rx_rd];
                        r.data_valid = 1'b1;
                        rx_rd = bump(rx_rd, RX_SLOTS);
                    end
                end
                MODE_SW_SEND:
                begin
                    nxt = bump(tx_wr, TX_SLOTS);
                    if (nxt == tx_rd)
                    begin
                        r.status = ST_TX_FULL;
                    end
                    else
                    begin
                        tx_mem[tx_wr] = d;
                        tx_wr  = nxt;
                        tx_req = 1'b1;
                    end
                end
                default:
                begin
                    if (!tx_req)
                    begin
                        r.status = ST_TX_IDLE;
                    end
                    else if (tx_wr == tx_rd)
                    begin
                        tx_req   = 1'b0;
                        r.status = ST_TX_IDLE;
                    end
                    else
                    begin
                        r.data_out   = tx_mem[tx_rd];
                        r.data_valid = 1'b1;
                        tx_rd = bump(tx_rd, TX_SLOTS);
                    end
                end
            endcase
            r.tx_request = tx_req;
            awaited.push_back(r);
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t exp;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: result with no request pending, got status %0d data %02h",
                             got.status, got.data_out);
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status || got.data_out !== exp.data_out ||
                got.data_valid !== exp.data_valid || got.tx_request !== exp.tx_request)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch at %0t: expected status %0d data %02h dv %0b txreq %0b,",
                             $realtime, exp.status, exp.data_out, exp.data_valid,
                             exp.tx_request,
                             " got status %0d data %02h dv %0b txreq %0b",
                             got.status, got.data_out, got.data_valid, got.tx_request);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    urb_cmd_if    cmd_ch ();
    urb_result_if res_ch ();

    ring_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    int unsigned    quiet_cycles;

    uart_rx_tx_ring_buffers #(
        .RX_DEPTH (RX_SLOTS),
        .TX_DEPTH (TX_SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch.sink),
        .result (res_ch.source)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        ring_result_t got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.status     = res_ch.status;
                got.data_out   = res_ch.data_out;
                got.data_valid = res_ch.data_valid;
                got.tx_request = res_ch.tx_request;
                sb.check_result(got);
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL uart_rx_tx_ring_buffers");
                $finish;
            end
        end
    end

    task automatic send_request(mode_t m, byte_t d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= m;
        cmd_ch.data_in <= d;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_request(m, d);
    endtask

    task automatic run_directed();
        send_request(MODE_SW_READ, 8'h00);
        send_request(MODE_TX_READY, 8'h00);
        send_request(MODE_RX_BYTE, 8'h00);
        send_request(MODE_RX_BYTE, 8'hFF);
        send_request(MODE_RX_BYTE, 8'hA5);
        send_request(MODE_RX_BYTE, 8'h5A);
        repeat (5) send_request(MODE_SW_READ, 8'h00);
        send_request(MODE_SW_SEND, 8'h00);
        send_request(MODE_SW_SEND, 8'hFF);
        send_request(MODE_SW_SEND, 8'h3C);
        repeat (3) send_request(MODE_TX_READY, 8'h00);
        // flag still set with an empty ring, then flag clear
        send_request(MODE_TX_READY, 8'h00);
        send_request(MODE_TX_READY, 8'h00);
        send_request(MODE_SW_READ, 8'hFF);
        send_request(MODE_TX_READY, 8'hFF);
    endtask

    task automatic run_random(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        mode_t       m;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 5)
            begin
                // burst of one event kind: fills and drains the rings past full and empty
                m   = mode_t'($urandom_range(MODE_TX_READY));
                len = ($urandom_range(2) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
                repeat (len) send_request(m, byte_t'($urandom_range(255)));
            end
            else
            begin
                len = $urandom_range(1, 20);
                repeat (len)
                    send_request(mode_t'($urandom_range(MODE_TX_READY)),
                                 byte_t'($urandom_range(255)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb             = new();
        cmd_ch.valid   <= 1'b0;
        cmd_ch.mode    <= MODE_RX_BYTE;
        cmd_ch.data_in <= '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);

        send_idle_pct  = 63;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 63;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_random(PHASE_ITEMS);

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("PASS uart_rx_tx_ring_buffers");
        else
            $display("FAIL uart_rx_tx_ring_buffers");
        $finish;
    end

endmodule
